FILE: src/per_cpu_page_frame_allocator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the per-CPU page frame allocator
// Shorthands for clocked assertions on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PER_CPU_PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define PER_CPU_PAGE_FRAME_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCPA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/pcpa_pkg.sv
// ----------------------------------------------------------------------------
// pcpa_pkg
// Shared types and constants of the per-CPU page frame allocator.
// ----------------------------------------------------------------------------
package pcpa_pkg;

  // Fixed field widths of the request, result and configuration beats.
  localparam int unsigned ADDR_W      = 40;
  localparam int unsigned CPU_FIELD_W = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned CFG_IDX_W   = 1;

  // Configuration register reset values.
  localparam logic [ADDR_W-1:0] KERNEL_END_RST = 40'h00_8000_0000;
  localparam logic [ADDR_W-1:0] PHYS_TOP_RST   = 40'h00_8800_0000;

  // Request kinds.
  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC    = 2'd0,
    ST_FREED    = 2'd1,
    ST_OOM      = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_END = 1'b0,
    CFG_PHYS_TOP   = 1'b1
  } cfg_reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the request beat and launch the link read
    logic fire;  // commit the state update and load the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_free;   // the captured request is a free
    logic mod_done;   // the link index of the freed page is ready
    logic slot_free;  // the result register can take a new beat
  } dp_status_t;

endpackage

FILE: src/pcpa_ram.sv
// ----------------------------------------------------------------------------
// pcpa_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module pcpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/pcpa_mod_unit.sv
// ----------------------------------------------------------------------------
// pcpa_mod_unit
// Reduces a page number modulo NUM_PAGES to a link memory index.
// ----------------------------------------------------------------------------
module pcpa_mod_unit import pcpa_pkg::*; #(
  parameter int unsigned NUM_PAGES  = 32768,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [ADDR_W-PAGE_SHIFT-1:0]    page_i,
  output logic                            done_o,
  output logic [$clog2(NUM_PAGES)-1:0]    idx_o
);

  localparam int unsigned IDX_W  = $clog2(NUM_PAGES);
  localparam int unsigned PAGE_W = ADDR_W - PAGE_SHIFT;

  if ((1 << IDX_W) == NUM_PAGES) begin : g_pow2
    logic [IDX_W-1:0] idx_q;

    // A power-of-two depth needs only the low bits of the page number.
    always_ff @(posedge clk_i) begin
      if (start_i) begin
        idx_q <= page_i[IDX_W-1:0];
      end
    end

    assign done_o = 1'b1;
    assign idx_o  = idx_q;
  end else begin : g_recip
    // The quotient is the page number times a rounded-up reciprocal of the
    // depth, shifted down; with this shift it is exact for every page number.
    localparam int unsigned     SHIFT_S = PAGE_W + IDX_W;
    localparam int unsigned     MUL_W   = PAGE_W + 1;
    localparam int unsigned     PROD_W  = PAGE_W + MUL_W;
    localparam longint unsigned RECIP_L =
      ((64'd1 << SHIFT_S) + 64'(NUM_PAGES) - 64'd1) / 64'(NUM_PAGES);
    localparam logic [MUL_W-1:0]  RECIP_C = MUL_W'(RECIP_L);
    localparam logic [PAGE_W-1:0] N_C     = PAGE_W'(NUM_PAGES);

    logic              busy_q;
    logic              done_q;
    logic [PAGE_W-1:0] page_q;
    logic [PROD_W-1:0] prod_q;
    logic [IDX_W-1:0]  idx_q;
    logic [PAGE_W-1:0] quot;
    logic [PAGE_W-1:0] rem_full;

    // Second stage: quotient from the product, remainder by one subtraction.
    always_comb begin
      quot     = PAGE_W'(prod_q >> SHIFT_S);
      rem_full = page_q - PAGE_W'(quot * N_C);
    end

    // Sequencing: the product at start, the remainder in the following cycle.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        busy_q <= 1'b0;
        done_q <= 1'b0;
      end else if (start_i) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
      end else if (busy_q) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end

    // Product, page number and remainder carry no reset.
    always_ff @(posedge clk_i) begin
      if (start_i) begin
        page_q <= page_i;
        prod_q <= PROD_W'(page_i) * PROD_W'(RECIP_C);
      end else if (busy_q) begin
        idx_q <= IDX_W'(rem_full);
      end
    end

    assign done_o = done_q;
    assign idx_o  = idx_q;
  end

endmodule

FILE: src/pcpa_ctrl.sv
// ----------------------------------------------------------------------------
// pcpa_ctrl
// Controller: accepts one request at a time and fires its commit.
// ----------------------------------------------------------------------------
module pcpa_ctrl import pcpa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t dp_status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   exec_go;

  // The commit waits for a free result slot and, for a free, the link index.
  assign exec_go = dp_status_i.slot_free &&
                   (!dp_status_i.req_free || dp_status_i.mod_done);

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o.load = in_valid_i && (state_q == S_IDLE);
  assign cmd_o.fire = (state_q == S_EXEC) && exec_go;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: src/pcpa_datapath.sv
// ----------------------------------------------------------------------------
// pcpa_datapath
// Pool heads, link memory, address checks and the result register.
// ----------------------------------------------------------------------------
module pcpa_datapath import pcpa_pkg::*; #(
  parameter int unsigned NUM_CPUS   = 8,
  parameter int unsigned NUM_PAGES  = 32768,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctrl_cmd_t              cmd_i,
  output dp_status_t             dp_status_o,
  input  logic                   cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ADDR_W-1:0]      cfg_data_i,
  input  logic                   req_type_i,
  input  logic [CPU_FIELD_W-1:0] cpu_i,
  input  logic [ADDR_W-1:0]      addr_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [STATUS_W-1:0]    out_status_o,
  output logic [ADDR_W-1:0]      out_page_addr_o,
  output logic [CPU_FIELD_W-1:0] out_served_by_o
);

  localparam int unsigned CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int unsigned IDX_W  = $clog2(NUM_PAGES);
  localparam int unsigned PAGE_W = ADDR_W - PAGE_SHIFT;
  localparam int unsigned LINK_W = 1 + PAGE_W + IDX_W;
  localparam int unsigned CPU_VALS = 1 << CPU_FIELD_W;

  // Configuration registers.
  logic [ADDR_W-1:0] kernel_end_q;
  logic [ADDR_W-1:0] phys_top_q;

  // Pool heads: page number, link index of that page, and a valid bit.
  logic [NUM_CPUS-1:0] pool_valid_q;
  logic [PAGE_W-1:0]   head_page_q [NUM_CPUS];
  logic [IDX_W-1:0]    head_idx_q  [NUM_CPUS];

  // Captured request and the head of the pool it works on.
  logic              req_q;
  logic [CPU_W-1:0]  own_q;
  logic [CPU_W-1:0]  src_q;
  logic              found_q;
  logic [ADDR_W-1:0] addr_q;
  logic              cur_valid_q;
  logic [PAGE_W-1:0] cur_page_q;
  logic [IDX_W-1:0]  cur_idx_q;

  // Result register.
  logic                   out_valid_q;
  logic [STATUS_W-1:0]    res_status_q;
  logic [ADDR_W-1:0]      res_page_addr_q;
  logic [CPU_FIELD_W-1:0] res_served_by_q;

  logic [CPU_FIELD_W-1:0] cpu_red;
  logic [CPU_W-1:0]       own_d;
  logic [CPU_W-1:0]       lowest_d;
  logic                   any_d;
  logic [CPU_W-1:0]       src_d;
  logic                   found_d;

  logic              mod_done;
  logic [IDX_W-1:0]  mod_idx;
  logic [LINK_W-1:0] link_rdata;
  logic              link_valid;
  logic [PAGE_W-1:0] link_page;
  logic [IDX_W-1:0]  link_idx;
  logic [PAGE_W-1:0] page_q;
  logic              bad_free;
  logic              push_en;
  logic              pop_en;
  status_e                res_status_d;
  logic [ADDR_W-1:0]      res_page_addr_d;
  logic [CPU_FIELD_W-1:0] res_served_by_d;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_end_q <= KERNEL_END_RST;
      phys_top_q   <= PHYS_TOP_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_KERNEL_END: kernel_end_q <= cfg_data_i;
        CFG_PHYS_TOP:   phys_top_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Requesting CPU folded onto the pools by repeated subtraction.
  always_comb begin
    cpu_red = cpu_i;
    for (int k = 0; k < CPU_VALS - 1; k++) begin
      if (32'(cpu_red) >= NUM_CPUS) begin
        cpu_red = cpu_red - CPU_FIELD_W'(NUM_CPUS);
      end
    end
    own_d = CPU_W'(cpu_red);
  end

  // Lowest-numbered pool that holds a page, for stealing.
  always_comb begin
    lowest_d = '0;
    any_d    = 1'b0;
    for (int i = NUM_CPUS - 1; i >= 0; i--) begin
      if (pool_valid_q[i]) begin
        lowest_d = CPU_W'(i);
        any_d    = 1'b1;
      end
    end
  end

  // A free and an allocate from a non-empty pool both work on the own pool.
  assign src_d   = (req_type_i == REQ_FREE || pool_valid_q[own_d]) ? own_d : lowest_d;
  assign found_d = pool_valid_q[own_d] || any_d;

  // Capture the request beat and the head of the selected pool.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q       <= req_type_i;
      own_q       <= own_d;
      src_q       <= src_d;
      found_q     <= found_d;
      addr_q      <= addr_i;
      cur_valid_q <= pool_valid_q[src_d];
      cur_page_q  <= head_page_q[src_d];
      cur_idx_q   <= head_idx_q[src_d];
    end
  end

  // Link index of the page being freed.
  pcpa_mod_unit #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.load && (req_type_i == REQ_FREE)),
    .page_i  (addr_i[ADDR_W-1:PAGE_SHIFT]),
    .done_o  (mod_done),
    .idx_o   (mod_idx)
  );

  // Next-link memory; the read of the popped head starts at acceptance.
  pcpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (NUM_PAGES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.fire && push_en),
    .waddr_i (mod_idx),
    .wdata_i ({cur_valid_q, cur_page_q, cur_idx_q}),
    .re_i    (cmd_i.load && (req_type_i == REQ_ALLOC)),
    .raddr_i (head_idx_q[src_d]),
    .rdata_o (link_rdata)
  );

  assign link_valid = link_rdata[LINK_W-1];
  assign link_page  = link_rdata[LINK_W-2:IDX_W];
  assign link_idx   = link_rdata[IDX_W-1:0];

  // Address check of a free: aligned and inside the managed range.
  assign page_q   = addr_q[ADDR_W-1:PAGE_SHIFT];
  assign bad_free = (|addr_q[PAGE_SHIFT-1:0]) || (addr_q < kernel_end_q) ||
                    (addr_q >= phys_top_q);

  // Result and state update selection.
  always_comb begin
    push_en         = 1'b0;
    pop_en          = 1'b0;
    res_status_d    = ST_OOM;
    res_page_addr_d = '0;
    res_served_by_d = '0;
    if (req_q == REQ_FREE) begin
      if (bad_free) begin
        res_status_d = ST_BAD_FREE;
      end else begin
        push_en         = 1'b1;
        res_status_d    = ST_FREED;
        res_served_by_d = CPU_FIELD_W'(own_q);
      end
    end else if (found_q) begin
      pop_en          = 1'b1;
      res_status_d    = ST_ALLOC;
      res_page_addr_d = {cur_page_q, {PAGE_SHIFT{1'b0}}};
      res_served_by_d = CPU_FIELD_W'(src_q);
    end
  end

  // Pool heads: a push makes the freed page the head, a pop follows the link.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_valid_q <= '0;
      for (int i = 0; i < NUM_CPUS; i++) begin
        head_page_q[i] <= '0;
        head_idx_q[i]  <= '0;
      end
    end else if (cmd_i.fire) begin
      if (push_en) begin
        pool_valid_q[own_q] <= 1'b1;
        head_page_q[own_q]  <= page_q;
        head_idx_q[own_q]   <= mod_idx;
      end else if (pop_en) begin
        pool_valid_q[src_q] <= link_valid;
        head_page_q[src_q]  <= link_valid ? link_page : '0;
        head_idx_q[src_q]   <= link_valid ? link_idx : '0;
      end
    end
  end

  // Result register: a new beat may load in the cycle the old one leaves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fire) begin
      res_status_q    <= res_status_d;
      res_page_addr_q <= res_page_addr_d;
      res_served_by_q <= res_served_by_d;
    end
  end

  assign dp_status_o.req_free  = (req_q == REQ_FREE);
  assign dp_status_o.mod_done  = mod_done;
  assign dp_status_o.slot_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign out_status_o    = res_status_q;
  assign out_page_addr_o = res_page_addr_q;
  assign out_served_by_o = res_served_by_q;

endmodule

FILE: src/per_cpu_page_frame_allocator.sv
// ----------------------------------------------------------------------------
// per_cpu_page_frame_allocator
// Per-CPU LIFO free lists of page frames, with stealing on an empty pool.
// ----------------------------------------------------------------------------
// Requests arrive as beats on the in_ channel (req_type_i, cpu_i, addr_i) and
// each one yields exactly one result beat on the out_ channel (status_o,
// page_addr_o, served_by_o). Both use valid/ready; a beat moves when both are
// high. The cfg_ channel writes kernel_end (index 0) and phys_top (index 1)
// and is always ready; write it only while no request is in flight.
// One request is worked on at a time. An allocate reads the next link of the
// pool head from the link memory in the accepting cycle; its commit in the
// execute state updates the head. A free waits for the link index: it is
// registered at acceptance when NUM_PAGES is a power of two; otherwise it
// comes from a two-stage reciprocal multiplication before the free commits.
// The result register parts the two sides: a new request is accepted while a
// result waits, and that request completes once the waiting beat is taken.
// Reset empties every pool and restores the two address bounds; the link
// memory needs no clearing, so requests are taken from the first cycle.
// ----------------------------------------------------------------------------
`include "per_cpu_page_frame_allocator_macros.svh"

module per_cpu_page_frame_allocator import pcpa_pkg::*; #(
  parameter int unsigned NUM_CPUS   = 8,
  parameter int unsigned NUM_PAGES  = 32768,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ADDR_W-1:0]      cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   req_type_i,
  input  logic [CPU_FIELD_W-1:0] cpu_i,
  input  logic [ADDR_W-1:0]      addr_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [ADDR_W-1:0]      page_addr_o,
  output logic [CPU_FIELD_W-1:0] served_by_o
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  // Configuration writes are registered and always accepted.
  assign cfg_ready_o = 1'b1;

  pcpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .dp_status_i (dp_status),
    .cmd_o       (cmd)
  );

  pcpa_datapath #(
    .NUM_CPUS   (NUM_CPUS),
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .dp_status_o     (dp_status),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (req_type_i),
    .cpu_i           (cpu_i),
    .addr_i          (addr_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .out_status_o    (status_o),
    .out_page_addr_o (page_addr_o),
    .out_served_by_o (served_by_o)
  );

  // Only one request is in flight: acceptance closes the input side.
  `PCPA_ASSERT_NEXT(a_single_item, in_valid_i && in_ready_o, !in_ready_o,
                    "second request taken while busy")

  // Only a successful allocate carries a page address.
  `PCPA_ASSERT_SAME(a_addr_zero, out_valid_o && (status_o != ST_ALLOC),
                    page_addr_o == '0, "page address on a non-allocate result")

  // Failed requests name no pool.
  `PCPA_ASSERT_SAME(a_fail_pool,
                    out_valid_o && (status_o == ST_OOM || status_o == ST_BAD_FREE),
                    served_by_o == '0, "pool named on a failed request")

  // Allocated pages are page aligned.
  `PCPA_ASSERT_SAME(a_page_align, out_valid_o && (status_o == ST_ALLOC),
                    page_addr_o[PAGE_SHIFT-1:0] == '0, "allocated page not aligned")

endmodule
